[design/pbc_pkg.sv]
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int POS_BITS    = 10;
  localparam int REGION_BITS = 11;
  localparam int COV_BITS    = 18;
  localparam int CMD_DEPTH   = 4;
  localparam int RES_DEPTH   = 2;

  localparam logic [REGION_BITS-1:0] REGION_RESET    = 11'd1024;
  localparam logic [REGION_BITS-1:0] COVERED_OUT_MAX = 11'd2047;
  localparam logic [3:0]             SUPPORT_CAP     = 4'd9;

  // lower-case ascii letters; flipping the case bit gives upper case
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_C = 8'h63;
  localparam logic [7:0] CHAR_LOW_G = 8'h67;
  localparam logic [7:0] CHAR_LOW_T = 8'h74;
  localparam logic [7:0] CHAR_CASE  = 8'h20;

  typedef enum logic [1:0] {
    OP_VOTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_VOTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    CODE_A = 3'd0,
    CODE_C = 3'd1,
    CODE_G = 3'd2,
    CODE_T = 3'd3,
    CODE_N = 3'd4
  } cons_code_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_dec_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                hit;
    logic [1:0]          base;
    logic [7:0]          weight;
    logic [POS_BITS-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [2:0]             code;
    logic [3:0]             support;
    logic                   flag;
    logic [REGION_BITS-1:0] covered;
  } res_t;

  function automatic base_dec_t base_decode(input logic [7:0] ch);
    base_dec_t d;
    d.valid = 1'b1;
    d.code  = 2'd0;
    unique case (ch)
      CHAR_LOW_A, CHAR_LOW_A ^ CHAR_CASE: d.code = 2'(CODE_A);
      CHAR_LOW_C, CHAR_LOW_C ^ CHAR_CASE: d.code = 2'(CODE_C);
      CHAR_LOW_G, CHAR_LOW_G ^ CHAR_CASE: d.code = 2'(CODE_G);
      CHAR_LOW_T, CHAR_LOW_T ^ CHAR_CASE: d.code = 2'(CODE_T);
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

[design/pbc_fifo.sv]
`timescale 1ns / 1ps

module pbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

[design/pbc_front.sv]
`timescale 1ns / 1ps

module pbc_front #(
  parameter int POSITIONS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pbc_pkg::REGION_BITS-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      opcode,
  input  logic [pbc_pkg::POS_BITS-1:0]    position,
  input  logic [7:0]                      base_char,
  input  logic [7:0]                      vote_weight,
  input  logic                            sweep_busy,
  input  logic                            cmd_pop,
  output pbc_pkg::cmd_t                   cmd_head,
  output logic                            cmd_empty
);

  logic [pbc_pkg::REGION_BITS-1:0] region_length;
  logic                            in_store;
  logic                            in_region;
  logic                            keep;
  logic                            q_full;
  logic                            accept;
  pbc_pkg::base_dec_t              dec;
  pbc_pkg::cmd_t                   cmd;
  logic [$bits(pbc_pkg::cmd_t)-1:0] head_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_length <= pbc_pkg::REGION_RESET;
    end else if (cfg_write) begin
      region_length <= cfg_data;
    end
  end

  assign full   = q_full || sweep_busy;
  assign accept = push && !full;

  // classify: drop what changes nothing, keep reads even when out of region
  always_comb begin
    in_store      = 32'(position) < POSITIONS;
    in_region     = in_store && (pbc_pkg::REGION_BITS'(position) < region_length);
    dec           = pbc_pkg::base_decode(base_char);
    cmd.kind      = pbc_pkg::CMD_VOTE;
    cmd.hit       = in_region;
    cmd.base      = dec.code;
    cmd.weight    = vote_weight;
    cmd.position  = position;
    keep          = 1'b0;
    unique case (opcode)
      pbc_pkg::OP_VOTE: begin
        cmd.kind = pbc_pkg::CMD_VOTE;
        keep     = in_region && dec.valid;
      end
      pbc_pkg::OP_READ: begin
        cmd.kind = pbc_pkg::CMD_READ;
        keep     = 1'b1;
      end
      pbc_pkg::OP_CLEAR: begin
        cmd.kind = pbc_pkg::CMD_CLEAR;
        keep     = in_store;
      end
      default: keep = 1'b0;
    endcase
  end

  pbc_fifo #(
    .WIDTH ($bits(pbc_pkg::cmd_t)),
    .DEPTH (pbc_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept && keep),
    .din   (cmd),
    .full  (q_full),
    .pop   (cmd_pop),
    .dout  (head_bits),
    .empty (cmd_empty)
  );

  assign cmd_head = pbc_pkg::cmd_t'(head_bits);

endmodule

[design/pbc_back.sv]
`timescale 1ns / 1ps

module pbc_back #(
  parameter int POSITIONS       = 1024,
  parameter int WEIGHT_SUM_BITS = 24,
  parameter int COUNT_BITS      = 16
) (
  input  logic          clk,
  input  logic          rst,
  output logic          sweep_busy,
  input  pbc_pkg::cmd_t cmd_head,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          res_push,
  output pbc_pkg::res_t res,
  input  logic          res_full
);

  localparam int IDX_W = $clog2(POSITIONS);
  localparam int CT_W  = $clog2(POSITIONS + 1);
  localparam int WSB   = WEIGHT_SUM_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int CVB   = pbc_pkg::COV_BITS;

  typedef enum logic [1:0] {
    S_SWEEP = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  state_t state;

  logic [3:0][WSB-1:0] sum_mem [POSITIONS];
  logic [3:0][CB-1:0]  cnt_mem [POSITIONS];
  logic [CVB-1:0]      cov_mem [POSITIONS];

  logic [3:0][WSB-1:0] rd_sum;
  logic [3:0][CB-1:0]  rd_cnt;
  logic [CVB-1:0]      rd_cov;

  logic [3:0][WSB-1:0] wr_sum;
  logic [3:0][CB-1:0]  wr_cnt;
  logic [CVB-1:0]      wr_cov;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    sweep_addr;

  pbc_pkg::cmd_t       cmd_q;
  logic [CT_W-1:0]     covered_total;
  logic [CT_W-1:0]     covered_total_next;
  logic                exec_done;
  logic                is_read;

  logic [WSB-1:0]      sum_sel;
  logic [WSB:0]        sum_add;
  logic [CB-1:0]       cnt_sel;
  logic                cov_zero;
  logic [1:0]          win_lo;
  logic [1:0]          win_hi;
  logic [1:0]          winner;
  logic [CB-1:0]       win_cnt;

  assign sweep_busy = (state == S_SWEEP);
  assign cmd_pop    = (state == S_IDLE) && !cmd_empty;
  assign rd_addr    = IDX_W'(cmd_head.position);
  assign wr_addr    = sweep_busy ? sweep_addr : IDX_W'(cmd_q.position);
  assign is_read    = (cmd_q.kind == pbc_pkg::CMD_READ);
  assign exec_done  = (state == S_EXEC) && !(is_read && res_full);
  assign res_push   = (state == S_EXEC) && is_read && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_addr    <= '0;
      covered_total <= '0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (sweep_addr == IDX_W'(POSITIONS - 1)) begin
            state <= S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cmd_q <= cmd_head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_done) begin
            covered_total <= covered_total_next;
            state         <= S_IDLE;
          end
        end
        default: state <= S_SWEEP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rd_sum <= sum_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
      rd_cov <= cov_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[wr_addr] <= wr_sum;
      cnt_mem[wr_addr] <= wr_cnt;
      cov_mem[wr_addr] <= wr_cov;
    end
  end

  always_comb begin
    sum_sel  = rd_sum[cmd_q.base];
    cnt_sel  = rd_cnt[cmd_q.base];
    cov_zero = (rd_cov == '0);
    sum_add  = {1'b0, sum_sel} + (WSB + 1)'(cmd_q.weight);

    wr_en              = 1'b0;
    wr_sum             = '0;
    wr_cnt             = '0;
    wr_cov             = '0;
    covered_total_next = covered_total;

    if (sweep_busy) begin
      wr_en = 1'b1;
    end else if (state == S_EXEC) begin
      unique case (cmd_q.kind)
        pbc_pkg::CMD_VOTE: begin
          wr_en  = 1'b1;
          wr_sum = rd_sum;
          wr_cnt = rd_cnt;
          wr_sum[cmd_q.base] = sum_add[WSB] ? '1 : sum_add[WSB-1:0];
          wr_cnt[cmd_q.base] = (cnt_sel == '1) ? cnt_sel : cnt_sel + 1'b1;
          wr_cov = (rd_cov == '1) ? rd_cov : rd_cov + 1'b1;
          if (cov_zero) begin
            covered_total_next = covered_total + 1'b1;
          end
        end
        pbc_pkg::CMD_CLEAR: begin
          wr_en = 1'b1;
          if (!cov_zero && covered_total != '0) begin
            covered_total_next = covered_total - 1'b1;
          end
        end
        pbc_pkg::CMD_READ: wr_en = 1'b0;
        default: wr_en = 1'b0;
      endcase
    end
  end

  // first maximum wins: pair winners, then the upper pair only if strictly larger
  always_comb begin
    win_lo  = (rd_sum[1] > rd_sum[0]) ? 2'd1 : 2'd0;
    win_hi  = (rd_sum[3] > rd_sum[2]) ? 2'd3 : 2'd2;
    winner  = (rd_sum[win_hi] > rd_sum[win_lo]) ? win_hi : win_lo;
    win_cnt = rd_cnt[winner];

    res.covered = (32'(covered_total) > 32'(pbc_pkg::COVERED_OUT_MAX)) ?
                  pbc_pkg::COVERED_OUT_MAX : pbc_pkg::REGION_BITS'(covered_total);
    if (cmd_q.hit && !cov_zero) begin
      res.code    = 3'(winner);
      res.support = (win_cnt > CB'(pbc_pkg::SUPPORT_CAP)) ? pbc_pkg::SUPPORT_CAP
                                                          : 4'(win_cnt);
      res.flag    = 1'b1;
    end else begin
      res.code    = pbc_pkg::CODE_N;
      res.support = '0;
      res.flag    = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(covered_total) <= POSITIONS)
    else $error("covered total above position count");

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> !cmd_pop && !res_push)
    else $error("command taken during clearing sweep");

  a_pop_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state == S_EXEC)
    else $error("popped command not executed");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !$past(exec_done) |-> $stable(covered_total))
    else $error("covered total moved outside execution");
`endif

endmodule

[design/pileup_base_consensus.sv]
`timescale 1ns / 1ps

// pileup consensus store: vote, read and clear transactions on one position each.
// the front decodes a transaction, drops votes for other characters or outside
// the region, clears past the store and unused opcodes in the cycle it takes
// them, and queues the rest (up to four). the back executes one queued
// transaction as a registered read of the position's row memory, then the
// saturating update and write back, or the winner pick for a read.
// it takes no new transaction until the last is done, since the row memory is
// read then written; dropped transactions cost the back nothing.
// after reset a clearing sweep zeroes the store one row per cycle, with full
// held high; region_length may be written meanwhile.
// read results wait in a two-entry result queue, so a stalled consumer only
// stops the back once that queue fills.

module pileup_base_consensus #(
  parameter int POSITIONS       = 1024,
  parameter int WEIGHT_SUM_BITS = 24,
  parameter int COUNT_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: region_length
  input  logic                            cfg_write,
  input  logic [pbc_pkg::REGION_BITS-1:0] cfg_data,
  // input transactions
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      opcode,
  input  logic [pbc_pkg::POS_BITS-1:0]    position,
  input  logic [7:0]                      base_char,
  input  logic [7:0]                      vote_weight,
  // result transactions
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      consensus_code,
  output logic [3:0]                      support_count,
  output logic                            covered_flag,
  output logic [pbc_pkg::REGION_BITS-1:0] covered_positions
);

  logic          sweep_busy;
  logic          cmd_pop;
  logic          cmd_empty;
  pbc_pkg::cmd_t cmd_head;
  logic          res_push;
  logic          res_full;
  pbc_pkg::res_t res_in;
  pbc_pkg::res_t res_out;
  logic [$bits(pbc_pkg::res_t)-1:0] res_bits;

  // decode and command queue
  pbc_front #(
    .POSITIONS (POSITIONS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .position    (position),
    .base_char   (base_char),
    .vote_weight (vote_weight),
    .sweep_busy  (sweep_busy),
    .cmd_pop     (cmd_pop),
    .cmd_head    (cmd_head),
    .cmd_empty   (cmd_empty)
  );

  // row memory, read-modify-write sequencer and covered count
  pbc_back #(
    .POSITIONS       (POSITIONS),
    .WEIGHT_SUM_BITS (WEIGHT_SUM_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .sweep_busy (sweep_busy),
    .cmd_head   (cmd_head),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .res_push   (res_push),
    .res        (res_in),
    .res_full   (res_full)
  );

  // result queue decouples the consumer from the back
  pbc_fifo #(
    .WIDTH ($bits(pbc_pkg::res_t)),
    .DEPTH (pbc_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

  assign res_out           = pbc_pkg::res_t'(res_bits);
  assign consensus_code    = res_out.code;
  assign support_count     = res_out.support;
  assign covered_flag      = res_out.flag;
  assign covered_positions = res_out.covered;

endmodule
